// ===== design/bptc_pkg.sv =====
package bptc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int DIV_STEPS   = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CAL       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_LOW  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_HIGH = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_CAL_NINE = 8'd3;

  localparam logic signed [33:0] T_OFFSET = 34'sd128000;
  localparam logic [20:0]        P_BASE   = 21'd1048576;
  localparam logic signed [16:0] P_SCALE  = 17'sd3125;
  localparam logic [31:0]        T_ROUND  = 32'd128;
  localparam logic [63:0]        X_BIAS   = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } bptc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
  } bptc_out_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_cal_low;
    logic [63:0] press_cal_high;
    logic [15:0] press_cal_nine;
  } bptc_cal_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [63:0] dividend;
    logic [30:0] divisor;
    logic        bad;
  } bptc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bptc_qstat_t;

  // low 64 bits of a times a 17-bit signed factor
  function automatic logic [63:0] mul64x17(input logic [63:0] a,
                                           input logic signed [16:0] b);
    logic signed [49:0] pl;
    logic signed [48:0] ph;
    pl = $signed({1'b0, a[31:0]}) * b;
    ph = $signed(a[63:32]) * b;
    return 64'(pl) + {ph[31:0], 32'd0};
  endfunction

  // low 64 bits of a 64 by 64 product
  function automatic logic [63:0] mul64lo(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [31:0] mid;
    ll  = a[31:0] * b[31:0];
    lh  = a[31:0] * b[63:32];
    hl  = a[63:32] * b[31:0];
    mid = lh[31:0] + hl[31:0];
    return ll + {mid, 32'd0};
  endfunction

endpackage

// ===== design/bptc_front.sv =====
module bptc_front import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bptc_in_t    in_word,
  input  bptc_cal_t   cal,
  input  bptc_qstat_t q_stat,
  output logic        push,
  output bptc_job_t   push_word
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] dd;
    logic [19:0] adp;
  } s1_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [19:0] adp;
  } s2_t;

  typedef struct packed {
    logic [31:0]        tc;
    logic [63:0]        xx;
    logic signed [49:0] xp5;
    logic signed [49:0] xp2;
    logic [19:0]        adp;
  } s3_t;

  typedef struct packed {
    logic [31:0]        tc;
    logic [63:0]        xxp6;
    logic [63:0]        xxp3;
    logic signed [49:0] xp5;
    logic signed [49:0] xp2;
    logic [19:0]        adp;
  } s4_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [63:0] y;
    logic [63:0] x3m;
    logic [19:0] adp;
  } s5_t;

  s1_t s1;
  s2_t s2;
  s3_t s3;
  s4_t s4;
  s5_t s5;
  bptc_job_t s6;
  logic [5:0] s_valid;
  logic adv;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;

  logic signed [17:0] ta, td;
  logic signed [33:0] a_full;
  logic signed [35:0] dd_full;
  logic signed [31:0] va, vb;
  logic signed [19:0] dds;
  logic signed [35:0] b_full;
  logic [31:0]        f5;
  logic signed [33:0] x;
  logic signed [67:0] xx_full;
  logic [63:0]        x2;
  logic [20:0]        pb;
  logic [63:0]        pd;

  assign t1 = cal.temp_cal[15:0];
  assign t2 = $signed(cal.temp_cal[31:16]);
  assign t3 = $signed(cal.temp_cal[47:32]);
  assign p1 = cal.press_cal_low[15:0];
  assign p2 = $signed(cal.press_cal_low[31:16]);
  assign p3 = $signed(cal.press_cal_low[47:32]);
  assign p4 = $signed(cal.press_cal_low[63:48]);
  assign p5 = $signed(cal.press_cal_high[15:0]);
  assign p6 = $signed(cal.press_cal_high[31:16]);

  assign adv      = !s_valid[5] || !q_stat.full;
  assign in_ready = adv;
  assign push     = s_valid[5] && !q_stat.full;
  assign push_word = s6;

  always_comb begin
    ta      = $signed({1'b0, in_word.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    td      = $signed({2'b0, in_word.raw_temperature[19:4]}) - $signed({2'b0, t1});
    a_full  = ta * t2;
    dd_full = td * td;

    va     = $signed(s1.a) >>> 11;
    dds    = 20'($signed(s1.dd) >>> 12);
    b_full = dds * t3;
    vb     = $signed(b_full[31:0]) >>> 14;

    f5      = s2.fine + {s2.fine[29:0], 2'b00} + T_ROUND;
    x       = 34'($signed(s2.fine)) - T_OFFSET;
    xx_full = x * x;

    x2 = 64'($signed(s4.xxp3) >>> 8) + (64'(s4.xp2) << 12);

    pb = P_BASE - {1'b0, s5.adp};
    pd = ({43'd0, pb} << 31) - s5.y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else if (adv) begin
      s_valid <= {s_valid[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.a   <= a_full[31:0];
      s1.dd  <= dd_full[31:0];
      s1.adp <= in_word.raw_pressure;

      s2.fine <= va + vb;
      s2.adp  <= s1.adp;

      s3.tc  <= 32'($signed(f5) >>> 8);
      s3.xx  <= xx_full[63:0];
      s3.xp5 <= x * p5;
      s3.xp2 <= x * p2;
      s3.adp <= s2.adp;

      s4.tc   <= s3.tc;
      s4.xxp6 <= mul64x17(s3.xx, 17'(p6));
      s4.xxp3 <= mul64x17(s3.xx, 17'(p3));
      s4.xp5  <= s3.xp5;
      s4.xp2  <= s3.xp2;
      s4.adp  <= s3.adp;

      s5.tc  <= s4.tc;
      s5.y   <= s4.xxp6 + (64'(s4.xp5) << 17) + (64'(p4) << 35);
      s5.x3m <= mul64x17(X_BIAS + x2, $signed({1'b0, p1}));
      s5.adp <= s4.adp;

      s6.tc       <= s5.tc;
      s6.dividend <= mul64x17(pd, P_SCALE);
      s6.divisor  <= s5.x3m[63:33];
      s6.bad      <= s5.x3m[63:33] == 31'd0;
    end
  end

endmodule

// ===== design/bptc_queue.sv =====
module bptc_queue import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bptc_job_t   push_word,
  input  logic        pop,
  output bptc_job_t   head,
  output bptc_qstat_t stat
);

  bptc_job_t  mem [0:1];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

endmodule

// ===== design/bptc_back.sv =====
module bptc_back import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bptc_cal_t   cal,
  input  bptc_qstat_t q_stat,
  input  bptc_job_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output bptc_out_t   out_word
);

  typedef struct packed {
    logic [30:0] r;
    logic [63:0] n;
    logic [30:0] ub;
    logic        neg;
    logic [31:0] tc;
    logic        bad;
  } dstage_t;

  typedef struct packed {
    logic [63:0] p;
    logic [63:0] a;
    logic [63:0] q2m;
    logic [31:0] tc;
    logic        bad;
  } post_t;

  dstage_t ds [0:DIV_STEPS];
  logic [DIV_STEPS:0] dv;
  post_t r1, r2;
  logic  r1_valid, r2_valid;
  logic  adv;

  logic signed [15:0] p7, p8, p9;
  logic [63:0] q, p, h1, h2, q1, q2, sum, res;

  assign p7 = $signed(cal.press_cal_high[47:32]);
  assign p8 = $signed(cal.press_cal_high[63:48]);
  assign p9 = $signed(cal.press_cal_nine);

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= '0;
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv        <= {dv[DIV_STEPS-1:0], !q_stat.empty};
      r1_valid  <= dv[DIV_STEPS];
      r2_valid  <= r1_valid;
      out_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].r   <= '0;
      ds[0].n   <= head.dividend[63] ? -head.dividend : head.dividend;
      ds[0].ub  <= head.divisor[30] ? -head.divisor : head.divisor;
      ds[0].neg <= head.dividend[63] ^ head.divisor[30];
      ds[0].tc  <= head.tc;
      ds[0].bad <= head.bad;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0] t;
    logic        ge;
    assign t  = {ds[k].r, ds[k].n[63]};
    assign ge = t >= {1'b0, ds[k].ub};
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k+1].r   <= ge ? 31'(t - {1'b0, ds[k].ub}) : t[30:0];
        ds[k+1].n   <= {ds[k].n[62:0], ge};
        ds[k+1].ub  <= ds[k].ub;
        ds[k+1].neg <= ds[k].neg;
        ds[k+1].tc  <= ds[k].tc;
        ds[k+1].bad <= ds[k].bad;
      end
    end
  end

  always_comb begin
    q   = ds[DIV_STEPS].n;
    p   = ds[DIV_STEPS].neg ? -q : q;
    h1  = 64'($signed(p) >>> 13);
    h2  = 64'($signed(r1.p) >>> 13);
    q1  = 64'($signed(r2.a) >>> 25);
    q2  = 64'($signed(r2.q2m) >>> 19);
    sum = r2.p + q1 + q2;
    res = 64'($signed(sum) >>> 8) + (64'(p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1.p   <= p;
      r1.a   <= mul64x17(h1, 17'(p9));
      r1.q2m <= mul64x17(p, 17'(p8));
      r1.tc  <= ds[DIV_STEPS].tc;
      r1.bad <= ds[DIV_STEPS].bad;

      r2.p   <= r1.p;
      r2.a   <= mul64lo(r1.a, h2);
      r2.q2m <= r1.q2m;
      r2.tc  <= r1.tc;
      r2.bad <= r1.bad;

      out_word.temp_centi       <= $signed(r2.tc);
      out_word.pressure_q24_8   <= r2.bad ? 32'd0 : res[31:0];
      out_word.pressure_invalid <= r2.bad;
    end
  end

endmodule

// ===== design/baro_temp_pressure_compensation.sv =====
// Integer temperature and pressure compensation. One word a cycle is taken and
// one result word a cycle is given while neither side stalls. In the pipeline,
// 6 front stages work out the temperature and the divisor chain, the
// 2-entry queue adds one, and the back has one setup stage, 64 stages of the
// one-bit-per-stage signed divider, and 3 stages for the quadratic correction
// and output register. A zero divisor yields pressure 0 with the invalid flag.
// Configuration is taken every cycle; write it only while the block is empty.
module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bptc_in_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bptc_out_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  bptc_cal_t   cal;
  bptc_qstat_t q_stat;
  bptc_job_t   push_word, head;
  logic        push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_CAL:       cal.temp_cal       <= cfg_data[47:0];
        REG_PRESS_CAL_LOW:  cal.press_cal_low  <= cfg_data;
        REG_PRESS_CAL_HIGH: cal.press_cal_high <= cfg_data;
        REG_PRESS_CAL_NINE: cal.press_cal_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_word, .cal, .q_stat, .push, .push_word
  );

  bptc_queue u_queue (
    .clk, .rst, .push, .push_word, .pop, .head, .stat(q_stat)
  );

  bptc_back u_back (
    .clk, .rst, .cal, .q_stat, .head, .pop, .out_valid, .out_ready, .out_word
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.pressure_invalid |-> out_word.pressure_q24_8 == 32'd0)
    else $error("invalid pressure word not zero");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule
